@@ hw/rtl/scbm_pkg.sv @@
package scbm_pkg;

  // Timer ticks per second and the prescaler width that holds 0 .. TICKS_PER_SECOND-1
  localparam int TICKS_PER_SECOND = 1000;
  localparam int PRESCALE_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

  // Menu items
  localparam logic [3:0] ITEM_MIN    = 4'd0;
  localparam logic [3:0] ITEM_HOUR   = 4'd1;
  localparam logic [3:0] ITEM_DAY    = 4'd2;
  localparam logic [3:0] ITEM_MONTH  = 4'd3;
  localparam logic [3:0] ITEM_YEAR   = 4'd4;
  localparam logic [3:0] ITEM_TEMP_SEL = 4'd5;  // selection index that opens temperature view
  localparam logic [3:0] ITEM_LAST_SLOT = 4'd9;
  localparam logic [3:0] ITEM_SELECT = 4'd10;
  localparam logic [3:0] ITEM_TEMP   = 4'd11;

  // Edit limits per item
  localparam logic [6:0] LIMIT_SELECT = 7'd9;
  localparam logic [6:0] LIMIT_MIN    = 7'd59;
  localparam logic [6:0] LIMIT_HOUR   = 7'd23;
  localparam logic [6:0] LIMIT_DAY    = 7'd31;
  localparam logic [6:0] LIMIT_MONTH  = 7'd12;
  localparam logic [6:0] LIMIT_YEAR   = 7'd99;
  localparam logic [6:0] LIMIT_TEMP   = 7'd0;

  // Temperature scale 488/1000 = 61/125; 1/125 as 67109 / 2^23 is exact for sample*61 < 2^16
  localparam int          TEMP_SHIFT = 23;
  localparam logic [21:0] TEMP_MULT  = 22'(61 * 67109);
  localparam logic [7:0]  TEMP_MAX   = 8'd255;

  // Key bit positions in a 4-bit key vector
  localparam int KEY_MENU   = 0;
  localparam int KEY_OPTION = 1;
  localparam int KEY_UP     = 2;
  localparam int KEY_DOWN   = 3;

  typedef struct packed {
    logic       command;
    logic       menu_key;
    logic       option_key;
    logic       up_key;
    logic       down_key;
    logic [9:0] temp_sample;
  } scbm_item_t;

  // Clock digit load request from the menu save path
  typedef struct packed {
    logic       min_load;
    logic       hr_load;
    logic [5:0] value;
  } scbm_load_t;

  // Binary 0..63 to BCD {tens[2:0], units[3:0]}; v*13>>7 equals v/10 over this range
  function automatic logic [6:0] bin_to_bcd(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [6:0] tens_x10;
    logic [6:0] units;
    prod     = 10'(v) * 10'd13;
    tens     = prod[9:7];
    tens_x10 = 7'(tens) * 7'd10;
    units    = {1'b0, v} - tens_x10;
    return {tens, units[3:0]};
  endfunction

endpackage

@@ hw/rtl/scbm_if.sv @@
interface scbm_in_if;
  import scbm_pkg::*;
  logic       valid;
  logic       ready;
  logic       command;
  logic       menu_key;
  logic       option_key;
  logic       up_key;
  logic       down_key;
  logic [9:0] temp_sample;

  modport source (output valid, command, menu_key, option_key, up_key, down_key, temp_sample,
                  input ready);
  modport sink   (input valid, command, menu_key, option_key, up_key, down_key, temp_sample,
                  output ready);
endinterface

interface scbm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hour_tens_digit;
  logic [3:0] hour_units_digit;
  logic [2:0] minute_tens_digit;
  logic [3:0] minute_units_digit;
  logic [2:0] second_tens_digit;
  logic [3:0] second_units_digit;
  logic       menu_on;
  logic [3:0] current_item;
  logic [6:0] edit_count;
  logic [7:0] degrees;

  modport source (output valid, hour_tens_digit, hour_units_digit, minute_tens_digit,
                  minute_units_digit, second_tens_digit, second_units_digit, menu_on,
                  current_item, edit_count, degrees, input ready);
  modport sink   (input valid, hour_tens_digit, hour_units_digit, minute_tens_digit,
                  minute_units_digit, second_tens_digit, second_units_digit, menu_on,
                  current_item, edit_count, degrees, output ready);
endinterface

@@ hw/rtl/settable_bcd_clock_menu_core.sv @@
// 24-hour BCD clock with a set menu. Every item on the input channel is either
// a timer tick (command 0) or a key and temperature scan (command 1), and every
// item yields exactly one result: the clock digits, menu state, edit value and
// scaled temperature as they stand after that item. Keys are active low and act
// on falling edges seen between scans; ticks ignore the key and sample fields.
// Each second takes TICKS_PER_SECOND ticks (package constant). An item is first
// held in the input register and then applied to the state registers, which
// serve as the result register; the block takes one item per clock while the
// result side takes results. The input side keeps accepting while a result
// waits, until one item is parked in the input register behind an untaken
// result.
module settable_bcd_clock_menu_core
  import scbm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  scbm_in_if.sink    items,
  scbm_out_if.source results
);

  // input register
  logic       in_vld;
  scbm_item_t in_reg;

  // result handshake
  logic out_vld;
  logic advance;   // result slot free or being drained this cycle
  logic fire;      // registered item is applied to the state this cycle
  logic tick;
  logic scan;

  scbm_load_t load;
  logic [3:0] keys;

  assign advance     = !out_vld || results.ready;
  assign fire        = in_vld && advance;
  assign tick        = fire && !in_reg.command;
  assign scan        = fire && in_reg.command;
  assign items.ready = !in_vld || advance;
  assign keys        = {in_reg.down_key, in_reg.up_key, in_reg.option_key, in_reg.menu_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (items.valid && items.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_reg.command     <= items.command;
      in_reg.menu_key    <= items.menu_key;
      in_reg.option_key  <= items.option_key;
      in_reg.up_key      <= items.up_key;
      in_reg.down_key    <= items.down_key;
      in_reg.temp_sample <= items.temp_sample;
    end
  end

  // The state registers only change on fire, and fire only happens when the
  // previous result is gone, so they serve directly as the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  assign results.valid = out_vld;

  scbm_clock u_clock (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .load      (load),
    .hr_tens   (results.hour_tens_digit),
    .hr_units  (results.hour_units_digit),
    .min_tens  (results.minute_tens_digit),
    .min_units (results.minute_units_digit),
    .sec_tens  (results.second_tens_digit),
    .sec_units (results.second_units_digit)
  );

  scbm_menu u_menu (
    .clk          (clk),
    .rst          (rst),
    .scan         (scan),
    .keys         (keys),
    .load         (load),
    .menu_on      (results.menu_on),
    .current_item (results.current_item),
    .edit_count   (results.edit_count)
  );

  scbm_temp u_temp (
    .clk         (clk),
    .rst         (rst),
    .scan        (scan),
    .temp_sample (in_reg.temp_sample),
    .degrees     (results.degrees)
  );

  // a consumed input item always produces a result
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_vld)
    else $error("item applied but no result");

  // input stalls only with an item parked behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> (in_vld && out_vld && !results.ready))
    else $error("input stalled without cause");

  // menu state moves only when an item is applied
  a_menu_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(results.edit_count) && $stable(results.current_item)
               && $stable(results.menu_on)))
    else $error("menu state changed without an item");

  // seconds digits stay in BCD range
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (results.second_units_digit <= 4'd9 && results.second_tens_digit <= 3'd5))
    else $error("seconds digit out of range");

endmodule

@@ hw/rtl/scbm_clock.sv @@
module scbm_clock
  import scbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  scbm_load_t load,
  output logic [1:0] hr_tens,
  output logic [3:0] hr_units,
  output logic [2:0] min_tens,
  output logic [3:0] min_units,
  output logic [2:0] sec_tens,
  output logic [3:0] sec_units
);

  logic [PRESCALE_W-1:0] prescaler, prescaler_next;
  logic [PRESCALE_W:0]   pre_inc;
  logic [1:0] hr_tens_next;
  logic [3:0] hr_units_next, min_units_next, sec_units_next;
  logic [2:0] min_tens_next, sec_tens_next;
  logic [4:0] su1, st1, mu1, mt1, hu1;
  logic [6:0] min_bcd, hr_bcd;

  always_comb begin
    prescaler_next = prescaler;
    sec_units_next = sec_units;
    sec_tens_next  = sec_tens;
    min_units_next = min_units;
    min_tens_next  = min_tens;
    hr_units_next  = hr_units;
    hr_tens_next   = hr_tens;
    pre_inc = {1'b0, prescaler} + 1'b1;
    su1 = 5'(sec_units) + 5'd1;
    st1 = 5'(sec_tens) + 5'd1;
    mu1 = 5'(min_units) + 5'd1;
    mt1 = 5'(min_tens) + 5'd1;
    hu1 = 5'(hr_units) + 5'd1;
    min_bcd = bin_to_bcd(load.value);
    hr_bcd  = bin_to_bcd({1'b0, load.value[4:0]});

    if (tick) begin
      prescaler_next = pre_inc[PRESCALE_W-1:0];
      if (pre_inc >= (PRESCALE_W+1)'(TICKS_PER_SECOND)) begin
        prescaler_next = '0;
        // BCD carry chain, seconds into hours
        if (su1 < 5'd10) begin
          sec_units_next = su1[3:0];
        end else begin
          sec_units_next = '0;
          if (st1 < 5'd6) begin
            sec_tens_next = st1[2:0];
          end else begin
            sec_tens_next = '0;
            if (mu1 < 5'd10) begin
              min_units_next = mu1[3:0];
            end else begin
              min_units_next = '0;
              if (mt1 < 5'd6) begin
                min_tens_next = mt1[2:0];
              end else begin
                min_tens_next = '0;
                hr_units_next = hu1[3:0];
                if (hu1 >= 5'd10) begin
                  hr_units_next = '0;
                  hr_tens_next  = hr_tens + 2'd1;
                end
                if (hr_tens_next == 2'd2 && hr_units_next == 4'd4) begin
                  hr_units_next = '0;
                  hr_tens_next  = '0;
                end
              end
            end
          end
        end
      end
    end

    if (load.min_load) begin
      min_tens_next  = min_bcd[6:4];
      min_units_next = min_bcd[3:0];
    end
    if (load.hr_load) begin
      hr_tens_next  = hr_bcd[5:4];
      hr_units_next = hr_bcd[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler <= '0;
      sec_units <= '0;
      sec_tens  <= '0;
      min_units <= '0;
      min_tens  <= '0;
      hr_units  <= '0;
      hr_tens   <= '0;
    end else begin
      prescaler <= prescaler_next;
      sec_units <= sec_units_next;
      sec_tens  <= sec_tens_next;
      min_units <= min_units_next;
      min_tens  <= min_tens_next;
      hr_units  <= hr_units_next;
      hr_tens   <= hr_tens_next;
    end
  end

endmodule

@@ hw/rtl/scbm_temp.sv @@
module scbm_temp
  import scbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       scan,
  input  logic [9:0] temp_sample,
  output logic [7:0] degrees
);

  logic [31:0] product;
  logic [8:0]  scaled;
  logic [7:0]  degrees_next;

  // sample * 488 / 1000 as one constant multiply and a shift
  assign product      = 32'(temp_sample) * 32'(TEMP_MULT);
  assign scaled       = product[TEMP_SHIFT +: 9];
  assign degrees_next = scaled[8] ? TEMP_MAX : scaled[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      degrees <= '0;
    end else if (scan) begin
      degrees <= degrees_next;
    end
  end

endmodule

@@ hw/rtl/scbm_menu.sv @@
module scbm_menu
  import scbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       scan,
  input  logic [3:0] keys,       // {down, up, option, menu}, 0 = pressed
  output scbm_load_t load,
  output logic       menu_on,
  output logic [3:0] current_item,
  output logic [6:0] edit_count
);

  logic [3:0] prev_keys;
  logic       save_pending, save_pending_next;
  logic [6:0] value_limit, value_limit_next;
  logic [5:0] stored_minute, stored_minute_next;
  logic [4:0] stored_hour, stored_hour_next;
  logic [4:0] stored_day, stored_day_next;
  logic [3:0] stored_month, stored_month_next;
  logic [6:0] stored_year, stored_year_next;
  logic       menu_on_next;
  logic [3:0] item_next;
  logic [6:0] edit_next;
  logic [3:0] fell;
  logic [3:0] sel;
  logic [6:0] edit_up;

  always_comb begin
    menu_on_next       = menu_on;
    item_next          = current_item;
    edit_next          = edit_count;
    save_pending_next  = save_pending;
    value_limit_next   = value_limit;
    stored_minute_next = stored_minute;
    stored_hour_next   = stored_hour;
    stored_day_next    = stored_day;
    stored_month_next  = stored_month;
    stored_year_next   = stored_year;
    load               = '0;
    load.value         = edit_count[5:0];
    fell               = prev_keys & ~keys;
    sel                = '0;
    edit_up            = '0;

    if (scan) begin
      if (fell[KEY_MENU]) begin
        menu_on_next = ~menu_on;
        if (!menu_on) begin
          item_next         = ITEM_SELECT;
          edit_next         = '0;
          save_pending_next = 1'b0;
        end
      end

      if (fell[KEY_OPTION] && menu_on_next) begin
        if (save_pending_next) begin
          // save; edit value still holds the value being stored
          unique case (item_next)
            ITEM_MIN: begin
              stored_minute_next = edit_next[5:0];
              load.min_load      = 1'b1;
            end
            ITEM_HOUR: begin
              stored_hour_next = edit_next[4:0];
              load.hr_load     = 1'b1;
            end
            ITEM_DAY:   stored_day_next   = edit_next[4:0];
            ITEM_MONTH: stored_month_next = edit_next[3:0];
            ITEM_YEAR:  stored_year_next  = edit_next;
            default: ;
          endcase
          save_pending_next = 1'b0;
          item_next         = ITEM_SELECT;
          edit_next         = '0;
        end else if (item_next == ITEM_SELECT) begin
          // selection index as it stands after a menu entry in the same scan
          sel               = (edit_next > 7'(ITEM_LAST_SLOT)) ? ITEM_LAST_SLOT :
                              edit_next[3:0];
          save_pending_next = 1'b1;
          edit_next         = '0;
          item_next         = (sel == ITEM_TEMP_SEL) ? ITEM_TEMP : sel;
          unique case (sel)
            ITEM_MIN:   edit_next = 7'(stored_minute);
            ITEM_HOUR:  edit_next = 7'(stored_hour);
            ITEM_DAY:   edit_next = 7'(stored_day);
            ITEM_MONTH: edit_next = 7'(stored_month);
            ITEM_YEAR:  edit_next = stored_year;
            default: ;
          endcase
        end
      end

      if (menu_on_next) begin
        unique case (item_next)
          ITEM_SELECT: value_limit_next = LIMIT_SELECT;
          ITEM_MIN:    value_limit_next = LIMIT_MIN;
          ITEM_HOUR:   value_limit_next = LIMIT_HOUR;
          ITEM_DAY:    value_limit_next = LIMIT_DAY;
          ITEM_MONTH:  value_limit_next = LIMIT_MONTH;
          ITEM_YEAR:   value_limit_next = LIMIT_YEAR;
          ITEM_TEMP:   value_limit_next = LIMIT_TEMP;
          default: ;
        endcase
      end

      if (item_next != ITEM_TEMP) begin
        if (fell[KEY_UP]) begin
          edit_up   = edit_next + 7'd1;
          edit_next = (edit_up > value_limit_next) ? 7'd0 : edit_up;
        end
        if (fell[KEY_DOWN]) begin
          edit_next = (edit_next == 7'd0) ? value_limit_next : edit_next - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys     <= '1;
      menu_on       <= 1'b0;
      current_item  <= ITEM_MIN;
      edit_count    <= '0;
      save_pending  <= 1'b0;
      value_limit   <= '0;
      stored_minute <= '0;
      stored_hour   <= '0;
      stored_day    <= '0;
      stored_month  <= '0;
      stored_year   <= '0;
    end else begin
      if (scan) begin
        prev_keys <= keys;
      end
      menu_on       <= menu_on_next;
      current_item  <= item_next;
      edit_count    <= edit_next;
      save_pending  <= save_pending_next;
      value_limit   <= value_limit_next;
      stored_minute <= stored_minute_next;
      stored_hour   <= stored_hour_next;
      stored_day    <= stored_day_next;
      stored_month  <= stored_month_next;
      stored_year   <= stored_year_next;
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  import scbm_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int BURST_TICKS   = 999;     // tops the prescaler up to one full second
  localparam int RANDOM_ITEMS  = 300;
  localparam int DRAIN_AT      = 150;     // random item index where the sender waits for empty
  localparam int STALL_AT      = BURST_TICKS + 100;  // result index where the sink holds off
  localparam int STALL_CYCLES  = 300;
  localparam int TAIL_CYCLES   = 20;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int REPORT_LIMIT  = 10;
  localparam int TEMP_NUM      = 488;
  localparam int TEMP_DEN      = 1000;

  // Everything the block reports after one item, in port order.
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic       menu_on;
    logic [3:0] current_item;
    logic [6:0] edit_count;
    logic [7:0] degrees;
  } readout_t;

  // One line of the directed script; want is used only when typed is set.
  typedef struct {
    scbm_item_t stim;
    int         reps;
    bit         typed;
    readout_t   want;
  } script_row_t;

  logic clk;
  logic rst;

  scbm_in_if  in_ch();
  scbm_out_if out_ch();

  settable_bcd_clock_menu_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: clock digits, menu machine, stores and key history
  // ---------------------------------------------------------------------------
  int unsigned prescale_cnt;
  logic [3:0]  sec_u, min_u, hr_u;
  logic [2:0]  sec_t, min_t;
  logic [1:0]  hr_t;
  logic        menu_st;
  logic [3:0]  item_st;
  logic [6:0]  edit_st;
  logic        save_armed;
  logic [6:0]  limit_st;
  logic [5:0]  kept_minute;
  logic [4:0]  kept_hour, kept_day;
  logic [3:0]  kept_month;
  logic [6:0]  kept_year;
  logic [3:0]  last_keys;
  logic [7:0]  temp_st;

  readout_t    expected_readouts[$];
  script_row_t script[$];
  logic [3:0]  held_keys;            // key levels of the random scan generator
  bit          burst;
  int          sent_count, tick_count, scan_count, rx_count, errors;
  int          menu_entries, temp_views, value_saves;

  function automatic void clock_reset();
    prescale_cnt = 0;
    {sec_u, sec_t, min_u, min_t, hr_u, hr_t} = '0;
    menu_st     = 1'b0;
    item_st     = ITEM_MIN;
    edit_st     = '0;
    save_armed  = 1'b0;
    limit_st    = '0;
    kept_minute = '0;
    kept_hour   = '0;
    kept_day    = '0;
    kept_month  = '0;
    kept_year   = '0;
    last_keys   = 4'hF;           // all released
    temp_st     = '0;
  endfunction

  // BCD ripple; hours wrap at 24 only when the minute carry lands on it
  function automatic void advance_second();
    sec_u = sec_u + 1'b1;
    if (sec_u < 10) return;
    sec_u = 0;
    sec_t = sec_t + 1'b1;
    if (sec_t < 6) return;
    sec_t = 0;
    min_u = min_u + 1'b1;
    if (min_u < 10) return;
    min_u = 0;
    min_t = min_t + 1'b1;
    if (min_t < 6) return;
    min_t = 0;
    hr_u = hr_u + 1'b1;
    if (hr_u >= 10) begin
      hr_u = 0;
      hr_t = hr_t + 1'b1;
    end
    if (hr_t == 2 && hr_u == 4) begin
      hr_u = 0;
      hr_t = 0;
    end
  endfunction

  // Option key while the menu is on: save an armed value, or open the selected item
  function automatic void press_option();
    logic [3:0] sel;
    if (save_armed) begin
      case (item_st)
        ITEM_MIN: begin
          kept_minute = edit_st[5:0];
          min_u = 4'(kept_minute % 10);
          min_t = 3'(kept_minute / 10);
        end
        ITEM_HOUR: begin
          kept_hour = edit_st[4:0];
          hr_u = 4'(kept_hour % 10);
          hr_t = 2'(kept_hour / 10);
        end
        ITEM_DAY:   kept_day   = edit_st[4:0];
        ITEM_MONTH: kept_month = edit_st[3:0];
        ITEM_YEAR:  kept_year  = edit_st;
        default: ;                          // empty slots and temperature store nothing
      endcase
      value_saves++;
      save_armed = 1'b0;
      item_st    = ITEM_SELECT;
      edit_st    = '0;
    end else if (item_st == ITEM_SELECT) begin
      sel = (edit_st > 9) ? ITEM_LAST_SLOT : edit_st[3:0];
      save_armed = 1'b1;
      edit_st    = '0;
      if (sel == ITEM_TEMP_SEL) begin
        item_st = ITEM_TEMP;
        temp_views++;
      end else begin
        item_st = sel;
        case (sel)
          ITEM_MIN:   edit_st = 7'(kept_minute);
          ITEM_HOUR:  edit_st = 7'(kept_hour);
          ITEM_DAY:   edit_st = 7'(kept_day);
          ITEM_MONTH: edit_st = 7'(kept_month);
          ITEM_YEAR:  edit_st = kept_year;
          default: ;
        endcase
      end
    end
  endfunction

  // Advances the predictor by one accepted item and returns the expected readout
  function automatic readout_t predict_readout(scbm_item_t it);
    readout_t    r;
    logic [3:0]  now_keys, fell;
    int unsigned scaled;
    if (it.command) begin
      now_keys[KEY_MENU]   = it.menu_key;
      now_keys[KEY_OPTION] = it.option_key;
      now_keys[KEY_UP]     = it.up_key;
      now_keys[KEY_DOWN]   = it.down_key;
      fell   = last_keys & ~now_keys;
      scaled = int'(it.temp_sample) * TEMP_NUM / TEMP_DEN;
      temp_st = (scaled > 255) ? TEMP_MAX : 8'(scaled);
      if (fell[KEY_MENU]) begin
        menu_st = !menu_st;
        if (menu_st) begin
          item_st    = ITEM_SELECT;
          edit_st    = '0;
          save_armed = 1'b0;
          menu_entries++;
        end
      end
      if (fell[KEY_OPTION] && menu_st) press_option();
      // limit only tracks the item while the menu is on; empty slots keep it
      if (menu_st) begin
        case (item_st)
          ITEM_SELECT: limit_st = LIMIT_SELECT;
          ITEM_MIN:    limit_st = LIMIT_MIN;
          ITEM_HOUR:   limit_st = LIMIT_HOUR;
          ITEM_DAY:    limit_st = LIMIT_DAY;
          ITEM_MONTH:  limit_st = LIMIT_MONTH;
          ITEM_YEAR:   limit_st = LIMIT_YEAR;
          ITEM_TEMP:   limit_st = LIMIT_TEMP;
          default: ;
        endcase
      end
      if (item_st != ITEM_TEMP) begin
        if (fell[KEY_UP]) begin
          edit_st = edit_st + 1'b1;
          if (edit_st > limit_st) edit_st = '0;
        end
        if (fell[KEY_DOWN]) begin
          if (edit_st == 0) edit_st = limit_st;
          else edit_st = edit_st - 1'b1;
        end
      end
      last_keys = now_keys;
    end else begin
      prescale_cnt++;
      if (prescale_cnt >= TICKS_PER_SECOND) begin
        prescale_cnt = 0;
        advance_second();
      end
    end
    r = {hr_t, hr_u, min_t, min_u, sec_t, sec_u, menu_st, item_st, edit_st, temp_st};
    return r;
  endfunction

  function automatic string show(readout_t r);
    return $sformatf("%0d%0d:%0d%0d:%0d%0d menu=%0d item=%0d edit=%0d deg=%0d",
                     r.hour_tens, r.hour_units, r.minute_tens, r.minute_units,
                     r.second_tens, r.second_units, r.menu_on, r.current_item,
                     r.edit_count, r.degrees);
  endfunction

  // Every fifth stretch of 40 items, and any burst, runs with no idling; otherwise a random idle gap per item
  function automatic int idle_draw(int n);
    if (burst) return 0;
    if ((n / 40) % 5 == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic note_mismatch(string what);
    errors++;
    if (errors <= REPORT_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // keys are given as levels {menu, option, up, down}, 0 = pressed
  task automatic add_row(input logic cmd, input logic [3:0] keys, input int temp,
                         input int reps, input bit typed, input readout_t want);
    script_row_t row;
    row.stim.command     = cmd;
    row.stim.menu_key    = keys[3];
    row.stim.option_key  = keys[2];
    row.stim.up_key      = keys[1];
    row.stim.down_key    = keys[0];
    row.stim.temp_sample = 10'(temp);
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endtask

  // Random item: ticks with junk key levels, mostly clean press/release scans, some noise
  function automatic scbm_item_t random_item();
    scbm_item_t it;
    int         pick;
    it.temp_sample = ($urandom_range(0, 7) == 0) ?
                     10'(($urandom_range(0, 1) == 1) ? 1023 : $urandom_range(0, 1) * 523)
                     : 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 9) < 4) begin
      it.command = 1'b0;
      {it.menu_key, it.option_key, it.up_key, it.down_key} = 4'($urandom);
      return it;
    end
    it.command = 1'b1;
    if ($urandom_range(0, 9) < 8) begin
      if (held_keys != 4'hF) begin
        held_keys = 4'hF;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      held_keys[KEY_OPTION] = 1'b0;
        else if (pick < 60) held_keys[KEY_UP]     = 1'b0;
        else if (pick < 85) held_keys[KEY_DOWN]   = 1'b0;
        else                held_keys[KEY_MENU]   = 1'b0;
      end
    end else begin
      held_keys = 4'($urandom);
    end
    it.menu_key   = held_keys[KEY_MENU];
    it.option_key = held_keys[KEY_OPTION];
    it.up_key     = held_keys[KEY_UP];
    it.down_key   = held_keys[KEY_DOWN];
    return it;
  endfunction

  // Offers one item after its idle gap, waits for the handshake, records the expectation.
  // With drain set the sender first waits until every outstanding result is back.
  task automatic send_item(input scbm_item_t it, input bit typed, input readout_t want,
                           input bit drain);
    int       gap;
    readout_t predicted;
    gap = idle_draw(sent_count);
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (drain) while (expected_readouts.size() != 0) @(negedge clk);
    in_ch.command     <= it.command;
    in_ch.menu_key    <= it.menu_key;
    in_ch.option_key  <= it.option_key;
    in_ch.up_key      <= it.up_key;
    in_ch.down_key    <= it.down_key;
    in_ch.temp_sample <= it.temp_sample;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_readout(it);
    expected_readouts.push_back(typed ? want : predicted);
    sent_count++;
    if (it.command) scan_count++;
    else tick_count++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, one long hold-off, in-order checking
  // ---------------------------------------------------------------------------
  initial begin : readout_monitor
    readout_t got, want;
    string    diff;
    int       gap;
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      // the long hold lets the block fill and push back on the sender
      gap = (rx_count == STALL_AT) ? STALL_CYCLES : idle_draw(rx_count);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.hour_tens_digit, out_ch.hour_units_digit, out_ch.minute_tens_digit,
             out_ch.minute_units_digit, out_ch.second_tens_digit, out_ch.second_units_digit,
             out_ch.menu_on, out_ch.current_item, out_ch.edit_count, out_ch.degrees};
      rx_count++;
      if (expected_readouts.size() == 0) begin
        note_mismatch($sformatf("result %0d with nothing expected: %s", rx_count, show(got)));
      end else begin
        want = expected_readouts.pop_front();
        diff = "";
        if (got.hour_tens    !== want.hour_tens)    diff = {diff, " hour_tens"};
        if (got.hour_units   !== want.hour_units)   diff = {diff, " hour_units"};
        if (got.minute_tens  !== want.minute_tens)  diff = {diff, " minute_tens"};
        if (got.minute_units !== want.minute_units) diff = {diff, " minute_units"};
        if (got.second_tens  !== want.second_tens)  diff = {diff, " second_tens"};
        if (got.second_units !== want.second_units) diff = {diff, " second_units"};
        if (got.menu_on      !== want.menu_on)      diff = {diff, " menu_on"};
        if (got.current_item !== want.current_item) diff = {diff, " current_item"};
        if (got.edit_count   !== want.edit_count)   diff = {diff, " edit_count"};
        if (got.degrees      !== want.degrees)      diff = {diff, " degrees"};
        if (diff != "")
          note_mismatch($sformatf("result %0d [%s ] expected %s got %s",
                                  rx_count, diff, show(want), show(got)));
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed script, one-second tick burst, then random items
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t row;
    readout_t    none;
    none = '0;
    rst  = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.command     = 1'b0;
    in_ch.menu_key    = 1'b1;
    in_ch.option_key  = 1'b1;
    in_ch.up_key      = 1'b1;
    in_ch.down_key    = 1'b1;
    in_ch.temp_sample = '0;
    held_keys = 4'hF;
    burst     = 1'b0;
    clock_reset();

    // Rows marked typed carry a hand-written readout; the rest go through the predictor.
    // Key levels are {menu, option, up, down}.
    add_row(1'b0, 4'b1111,    0, 1, 1'b1, '0);                           // tick out of reset
    add_row(1'b1, 4'b1111, 1023, 1, 1'b1,
            {2'd0, 4'd0, 3'd0, 4'd0, 3'd0, 4'd0, 1'b0, ITEM_MIN, 7'd0, TEMP_MAX});  // clips
    add_row(1'b1, 4'b1111,    0, 1, 1'b1, '0);                           // coldest reading
    add_row(1'b1, 4'b1110,  522, 1, 1'b0, none);  // down with menu off: stale limit 0
    add_row(1'b1, 4'b1101,  523, 1, 1'b0, none);  // up past stale limit; scale edge at 255
    add_row(1'b1, 4'b0111,    0, 1, 1'b1,
            {2'd0, 4'd0, 3'd0, 4'd0, 3'd0, 4'd0, 1'b1, ITEM_SELECT, 7'd0, 8'd0}); // menu on
    add_row(1'b1, 4'b1110,  700, 1, 1'b0, none);  // down wrap to 9
    add_row(1'b1, 4'b1101,  700, 1, 1'b0, none);  // up wrap to 0
    add_row(1'b1, 4'b1110,  100, 1, 1'b0, none);  // back to 9
    add_row(1'b1, 4'b1011,  100, 1, 1'b0, none);  // open empty slot 9
    add_row(1'b1, 4'b1101,  200, 1, 1'b0, none);  // edit in empty slot, limit left over
    add_row(1'b1, 4'b1011,  200, 1, 1'b0, none);  // save in empty slot stores nothing
    add_row(1'b1, 4'b1110,  300, 1, 1'b0, none);
    add_row(1'b1, 4'b1101,  300, 1, 1'b0, none);  // selection back at 0
    add_row(1'b1, 4'b1011,  400, 1, 1'b0, none);  // open minutes
    add_row(1'b1, 4'b1110,  400, 1, 1'b0, none);  // down wrap to 59
    add_row(1'b1, 4'b1011,  500, 1, 1'b0, none);  // save minutes into the clock
    add_row(1'b1, 4'b1101,  500, 1, 1'b0, none);
    add_row(1'b1, 4'b1011,  600, 1, 1'b0, none);  // open hours
    add_row(1'b1, 4'b1110,  600, 1, 1'b0, none);  // down wrap to 23
    add_row(1'b1, 4'b1011,  800, 1, 1'b0, none);  // save hours: clock now 23:59
    add_row(1'b1, 4'b0111,  800, 1, 1'b0, none);  // menu off
    add_row(1'b1, 4'b1110,  900, 1, 1'b0, none);  // edit with menu off, limit left at 9
    // a second's worth of ticks moves the clock to 23:59:01; key and sample junk is ignored
    add_row(1'b0, 4'b0000, 1023, BURST_TICKS, 1'b0, none);
    add_row(1'b1, 4'b1111,  512, 1, 1'b0, none);  // key history untouched by the ticks

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row   = script[i];
      burst = (row.reps > 1);
      repeat (row.reps) send_item(row.stim, row.typed, row.want, 1'b0);
    end
    burst = 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_item(random_item(), 1'b0, none, n == DRAIN_AT);

    in_ch.valid <= 1'b0;
    while (expected_readouts.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run: %0d items (%0d ticks, %0d scans), %0d readouts checked, %0d mismatches",
             sent_count, tick_count, scan_count, rx_count, errors);
    $display("Menu: %0d entries, %0d saves, %0d temperature views, clock ended at %0d%0d:%0d%0d",
             menu_entries, value_saves, temp_views, hr_t, hr_u, min_t, min_u);
    if (errors == 0 && expected_readouts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/scbm_pkg.sv
hw/rtl/scbm_if.sv
hw/rtl/scbm_clock.sv
hw/rtl/scbm_temp.sv
hw/rtl/scbm_menu.sv
hw/rtl/settable_bcd_clock_menu_core.sv
verif/tb_top.sv
